// File: rtl/ordered_list_positional_ops_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_POSITIONAL_OPS_ASSERT_SVH
`define ORDERED_LIST_POSITIONAL_OPS_ASSERT_SVH

// consequent must hold in the same cycle
`define OLPO_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("olpo: assertion failed");

// consequent must hold in the next cycle
`define OLPO_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("olpo: assertion failed");

`endif

// File: rtl/olpo_pkg.sv
// ----------------------------------------------------------------------------
// olpo_pkg
// Types, codes and sizes shared by the ordered list blocks.
// ----------------------------------------------------------------------------
package olpo_pkg;

    localparam int CAPACITY  = 16;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 5;
    localparam int IDX_OUT_W = 4;
    localparam int LEN_W     = 5;
    localparam int STAT_W    = 2;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP_SIZE = 4;
    localparam int LIDX_W   = 2;
    localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] OP_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] OP_FIND   = 3'd2;
    localparam logic [FUNC_W-1:0] OP_ARGMIN = 3'd3;
    localparam logic [FUNC_W-1:0] OP_ARGMAX = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_LEFT,
        CMD_RIGHT
    } cell_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_REDUCE
    } fsm_state_t;

    typedef struct packed {
        logic              vld;
        data_t             value;
        logic [LIDX_W-1:0] lidx;
    } grp_res_t;

    typedef struct packed {
        logic             vld;
        data_t            value;
        logic [IDX_W-1:0] idx;
    } best_t;

endpackage

// File: rtl/olpo_if.sv
// ----------------------------------------------------------------------------
// olpo_if
// Request and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface olpo_req_if import olpo_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    data_t             value;

    modport source (output valid, func, position, value, input ready);
    modport sink   (input valid, func, position, value, output ready);
endinterface

interface olpo_rsp_if import olpo_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [IDX_OUT_W-1:0] index;
    logic [LEN_W-1:0]     length;
    logic [STAT_W-1:0]    status;

    modport source (output valid, found, index, length, status, input ready);
    modport sink   (input valid, found, index, length, status, output ready);
endinterface

// File: rtl/olpo_cell.sv
// ----------------------------------------------------------------------------
// olpo_cell
// One list slot: holds, loads or shifts in a neighbor's entry; match compare.
// ----------------------------------------------------------------------------
module olpo_cell import olpo_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  data_t     left_val,
    input  data_t     right_val,
    input  data_t     new_val,
    input  data_t     key,
    input  logic      valid,
    output data_t     entry,
    output logic      match
);

    data_t entry_reg;
    data_t entry_next;

    always_comb
    begin
        unique case (cmd)
            CMD_HOLD:  entry_next = entry_reg;
            CMD_LOAD:  entry_next = new_val;
            CMD_LEFT:  entry_next = left_val;
            CMD_RIGHT: entry_next = right_val;
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = valid && (entry_reg == key);

endmodule

// File: rtl/olpo_group.sv
// ----------------------------------------------------------------------------
// olpo_group
// Two-level tournament over four slots; lower index wins ties.
// ----------------------------------------------------------------------------
module olpo_group import olpo_pkg::*;
(
    input  data_t          vals [GRP_SIZE],
    input  logic           vlds [GRP_SIZE],
    input  logic           want_max,
    output grp_res_t       best
);

    function automatic grp_res_t pick(grp_res_t a, grp_res_t b, logic mx);
        logic better;
        better = b.vld && (!a.vld || (mx ? (b.value > a.value) : (b.value < a.value)));
        return better ? b : a;
    endfunction

    grp_res_t c [GRP_SIZE];
    grp_res_t w0;
    grp_res_t w1;

    always_comb
    begin
        for (int j = 0; j < GRP_SIZE; j++)
        begin
            c[j].vld   = vlds[j];
            c[j].value = vals[j];
            c[j].lidx  = LIDX_W'(j);
        end
        w0   = pick(c[0], c[1], want_max);
        w1   = pick(c[2], c[3], want_max);
        best = pick(w0, w1, want_max);
    end

endmodule

// File: rtl/ordered_list_positional_ops.sv
// ----------------------------------------------------------------------------
// ordered_list_positional_ops
// Bounded ordered list of signed values held in a chain of shift cells.
// ----------------------------------------------------------------------------
// Insert, delete, find, unused codes, argmin/argmax on an empty list: answered in the
//   cycle after the request is taken. Argmin and argmax on a non-empty list: the registered group
//   tournament stage, then the group-to-group reduce into the output register once the output is free.
// Throughput: one item per cycle unless the response stalls; non-empty argmin/argmax holds off the next request.
// Reset: list length cleared to zero, no result pending; entries undefined.
// ----------------------------------------------------------------------------
module ordered_list_positional_ops import olpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    olpo_req_if.sink    req,
    olpo_rsp_if.source  rsp
);

    `include "ordered_list_positional_ops_assert.svh"

    fsm_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             want_max_reg, want_max_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg, found_next;
    logic [IDX_OUT_W-1:0] index_reg, index_next;
    logic [LEN_W-1:0]     length_reg, length_next;
    logic [STAT_W-1:0]    status_reg, status_next;

    best_t grp_reg [NUM_GRP];
    best_t grp_next [NUM_GRP];
    logic  grp_load;

    data_t     entry [CAPACITY];
    data_t     left_v [CAPACITY];
    data_t     right_v [CAPACITY];
    logic      match [CAPACITY];
    logic      vld [CAPACITY];
    cell_cmd_t cmd [CAPACITY];

    data_t    pad_val [NUM_GRP*GRP_SIZE];
    logic     pad_vld [NUM_GRP*GRP_SIZE];
    grp_res_t grp_out [NUM_GRP];

    logic             req_fire;
    logic             out_free;
    logic [CMP_W-1:0] pos_c, cnt_c, eff_pos;
    logic             ins_ok, del_ok, any_match, is_ext;
    best_t            fin;

    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_fire = req.valid && req.ready;

    assign pos_c   = CMP_W'(req.position);
    assign cnt_c   = CMP_W'(count_reg);
    assign eff_pos = (pos_c > cnt_c) ? cnt_c : pos_c;
    assign ins_ok  = (req.func == OP_INSERT) && (cnt_c < CMP_W'(CAPACITY));
    assign del_ok  = (req.func == OP_DELETE) && (pos_c < cnt_c);
    assign is_ext  = (req.func == OP_ARGMIN) || (req.func == OP_ARGMAX);

    genvar gk;
    generate
        for (gk = 0; gk < CAPACITY; gk++)
        begin : g_cell
            if (gk == 0)
            begin : g_first
                assign left_v[gk] = entry[gk];
            end
            else
            begin : g_mid
                assign left_v[gk] = entry[gk-1];
            end
            if (gk == CAPACITY - 1)
            begin : g_last
                assign right_v[gk] = entry[gk];
            end
            else
            begin : g_inner
                assign right_v[gk] = entry[gk+1];
            end
            assign vld[gk] = CMP_W'(gk) < cnt_c;

            olpo_cell u_cell (
                .clk       (clk),
                .cmd       (cmd[gk]),
                .left_val  (left_v[gk]),
                .right_val (right_v[gk]),
                .new_val   (req.value),
                .key       (req.value),
                .valid     (vld[gk]),
                .entry     (entry[gk]),
                .match     (match[gk])
            );
        end

        for (gk = 0; gk < NUM_GRP*GRP_SIZE; gk++)
        begin : g_pad
            if (gk < CAPACITY)
            begin : g_real
                assign pad_val[gk] = entry[gk];
                assign pad_vld[gk] = vld[gk];
            end
            else
            begin : g_fill
                assign pad_val[gk] = '0;
                assign pad_vld[gk] = 1'b0;
            end
        end

        for (gk = 0; gk < NUM_GRP; gk++)
        begin : g_grp
            olpo_group u_group (
                .vals     (pad_val[gk*GRP_SIZE +: GRP_SIZE]),
                .vlds     (pad_vld[gk*GRP_SIZE +: GRP_SIZE]),
                .want_max (req.func == OP_ARGMAX),
                .best     (grp_out[gk])
            );
        end
    endgenerate

    always_comb
    begin
        any_match = 1'b0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            any_match = any_match | match[k];
            cmd[k] = CMD_HOLD;
            if (req_fire && ins_ok)
            begin
                if (CMP_W'(k) == eff_pos)
                    cmd[k] = CMD_LOAD;
                else if (CMP_W'(k) > eff_pos)
                    cmd[k] = CMD_LEFT;
            end
            else if (req_fire && del_ok && (CMP_W'(k) >= pos_c))
            begin
                cmd[k] = CMD_RIGHT;
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_next[g].vld   = grp_out[g].vld;
            grp_next[g].value = grp_out[g].value;
            grp_next[g].idx   = IDX_W'(g * GRP_SIZE) + IDX_W'(grp_out[g].lidx);
        end
        fin = grp_reg[0];
        for (int g = 1; g < NUM_GRP; g++)
        begin
            if (grp_reg[g].vld && (!fin.vld ||
                (want_max_reg ? (grp_reg[g].value > fin.value)
                              : (grp_reg[g].value < fin.value))))
                fin = grp_reg[g];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        want_max_next  = want_max_reg;
        grp_load       = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        found_next     = found_reg;
        index_next     = index_reg;
        length_next    = length_reg;
        status_next    = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (ins_ok)
                        count_next = count_reg + CNT_W'(1);
                    else if (del_ok)
                        count_next = count_reg - CNT_W'(1);

                    if (is_ext && (count_reg != '0))
                    begin
                        grp_load      = 1'b1;
                        want_max_next = (req.func == OP_ARGMAX);
                        state_next    = S_REDUCE;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        found_next     = (req.func == OP_FIND) && any_match;
                        index_next     = '0;
                        length_next    = LEN_W'(count_next);
                        priority if ((req.func == OP_INSERT) && !ins_ok)
                            status_next = ST_FULL;
                        else if ((req.func == OP_DELETE) && !del_ok)
                            status_next = ST_EMPTY;
                        else if (is_ext)
                            status_next = ST_EMPTY;
                        else
                            status_next = ST_OK;
                    end
                end
            end
            S_REDUCE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    index_next     = IDX_OUT_W'(fin.idx);
                    length_next    = LEN_W'(count_reg);
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_max_reg <= want_max_next;
        found_reg    <= found_next;
        index_reg    <= index_next;
        length_reg   <= length_next;
        status_reg   <= status_next;
        if (grp_load)
        begin
            for (int g = 0; g < NUM_GRP; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.found  = found_reg;
    assign rsp.index  = index_reg;
    assign rsp.length = length_reg;
    assign rsp.status = status_reg;

    `OLPO_ASSERT_NOW(a_count_bound, 1'b1, cnt_c <= CMP_W'(CAPACITY))
    `OLPO_ASSERT_NEXT(a_insert_grows, req_fire && ins_ok, count_reg == $past(count_reg) + CNT_W'(1))
    `OLPO_ASSERT_NEXT(a_reduce_exit, (state_reg == S_REDUCE) && out_free, state_reg == S_IDLE)
    `OLPO_ASSERT_NOW(a_reduce_blocks, state_reg == S_REDUCE, !req.ready)

endmodule
